// File: hw/rtl/bws2d_pkg.sv
`default_nettype none

package bws2d_pkg;

  // Storage bounds used by default
  localparam int DefaultMaxSize   = 64;
  localparam int DefaultMaxWindow = 8;

  // Field widths
  localparam int SampleW     = 8;
  localparam int ImageSizeW  = 7;
  localparam int WindowSizeW = 4;
  localparam int CfgDataW    = 7;
  localparam int BoxSumW     = 14;
  localparam int CoordW      = 6;
  localparam int OutDataW    = 32;
  localparam int OutPadW     = OutDataW - BoxSumW - 2 * CoordW;

  // Register values after reset
  localparam logic [ImageSizeW-1:0]  ImageSizeReset  = 7'd5;
  localparam logic [WindowSizeW-1:0] WindowSizeReset = 4'd3;

  // Configuration register indexes
  typedef enum logic [0:0] {
    RegImageSize  = 1'b0,
    RegWindowSize = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: hw/rtl/box_window_sum_2d.sv
`default_nettype none

// Streaming 2D box sum. Matrix elements arrive in raster order on the slave
// stream, one item per clock at full rate; tuser marks the first element of
// a matrix. For every window_size x window_size block that is fully covered
// the block emits one item with the block sum and the window's top-left
// row and column; tlast flags the final window of the matrix. An accepted
// element is registered into stage B with the row-ring and column-sum
// reads; when the output register is free or being taken, stage B loads
// the column and row running-sum update into the output register.
// Sustained throughput is one item per cycle, limited only by the output
// side taking items. Write image_size and window_size only while the block
// is idle; any write restarts the position at row 0, column 0. Out-of-range
// values are clamped to 1..MAX_SIZE and 1..MAX_WINDOW; if the window is
// larger than the matrix no results appear.
module box_window_sum_2d #(
  parameter int MAX_SIZE   = bws2d_pkg::DefaultMaxSize,
  parameter int MAX_WINDOW = bws2d_pkg::DefaultMaxWindow
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write channel
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [0:0]                        cfg_index_i,
  input  wire logic [bws2d_pkg::CfgDataW-1:0]    cfg_data_i,
  // Input stream
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  input  wire logic [bws2d_pkg::SampleW-1:0]     s_axis_tdata,  // [7:0] sample
  input  wire logic                              s_axis_tuser,  // [0] frame_start
  // Result stream
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [13:0] box_sum, [19:14] window_row, [25:20] window_col, [31:26] zero
  output      logic [bws2d_pkg::OutDataW-1:0]    m_axis_tdata,
  output      logic                              m_axis_tlast   // last_window
);

  localparam int SampleMax = (1 << bws2d_pkg::SampleW) - 1;
  localparam int SizeW     = $clog2(MAX_SIZE);
  localparam int NW        = $clog2(MAX_SIZE + 1);
  // Common width for position compares: holds image_size, window_size, r+1
  localparam int CmpW      = ((NW > bws2d_pkg::ImageSizeW) ? NW : bws2d_pkg::ImageSizeW) + 1;
  localparam int HW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RingDepth = MAX_WINDOW * MAX_SIZE;
  localparam int RingAW    = $clog2(RingDepth);
  localparam int ColW      = $clog2(SampleMax * MAX_WINDOW + 1);
  localparam int BoxW      = $clog2(SampleMax * MAX_WINDOW * MAX_WINDOW + 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [bws2d_pkg::ImageSizeW-1:0]  image_size_q;
  logic [bws2d_pkg::WindowSizeW-1:0] window_size_q;
  logic                              cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q  <= bws2d_pkg::ImageSizeReset;
      window_size_q <= bws2d_pkg::WindowSizeReset;
    end else if (cfg_fire) begin
      unique case (bws2d_pkg::cfg_reg_e'(cfg_index_i))
        bws2d_pkg::RegImageSize:  image_size_q  <= cfg_data_i;
        bws2d_pkg::RegWindowSize: window_size_q <= cfg_data_i[bws2d_pkg::WindowSizeW-1:0];
      endcase
    end
  end

  // Clamp the registers to the supported range
  logic [CmpW-1:0] n_eff;
  logic [CmpW-1:0] w_eff;

  always_comb begin
    n_eff = CmpW'(image_size_q);
    if (n_eff == '0) begin
      n_eff = CmpW'(1);
    end else if (n_eff > CmpW'(MAX_SIZE)) begin
      n_eff = CmpW'(MAX_SIZE);
    end
    w_eff = CmpW'(window_size_q);
    if (w_eff == '0) begin
      w_eff = CmpW'(1);
    end else if (w_eff > CmpW'(MAX_WINDOW)) begin
      w_eff = CmpW'(MAX_WINDOW);
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: position tracking and memory read issue
  // ---------------------------------------------------------------------
  logic [SizeW-1:0] row_q, col_q;
  logic [HW-1:0]    ptr_q;

  logic             s_fire;
  logic             restart;
  logic [SizeW-1:0] row_a, col_a;
  logic [HW-1:0]    ptr_a;
  logic [CmpW-1:0]  row_p1, col_p1, ptr_p1;
  logic [SizeW-1:0] row_nx, col_nx;
  logic [HW-1:0]    ptr_nx;
  logic [RingAW-1:0] ring_addr_a;
  logic             emit_a, last_a;

  assign s_fire = s_axis_tvalid & s_axis_tready;

  always_comb begin
    restart = s_axis_tuser
           || (CmpW'(row_q) >= n_eff)
           || (CmpW'(col_q) >= n_eff)
           || (CmpW'(ptr_q) >= w_eff);
    row_a  = restart ? '0 : row_q;
    col_a  = restart ? '0 : col_q;
    ptr_a  = restart ? '0 : ptr_q;
    row_p1 = CmpW'(row_a) + CmpW'(1);
    col_p1 = CmpW'(col_a) + CmpW'(1);
    ptr_p1 = CmpW'(ptr_a) + CmpW'(1);

    // Advance through the raster; wrap the ring row at window_size rows
    row_nx = row_a;
    if (col_p1 < n_eff) begin
      col_nx = SizeW'(col_p1);
      ptr_nx = ptr_a;
    end else begin
      col_nx = '0;
      ptr_nx = (ptr_p1 >= w_eff) ? '0 : HW'(ptr_p1);
      if (row_p1 < n_eff) begin
        row_nx = SizeW'(row_p1);
      end else begin
        row_nx = '0;
        ptr_nx = '0;
      end
    end

    ring_addr_a = RingAW'(ptr_a) * RingAW'(MAX_SIZE) + RingAW'(col_a);
    emit_a = (w_eff <= n_eff) && (row_p1 >= w_eff) && (col_p1 >= w_eff);
    last_a = (row_p1 == n_eff) && (col_p1 == n_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      ptr_q <= '0;
    end else if (cfg_fire) begin
      row_q <= '0;
      col_q <= '0;
      ptr_q <= '0;
    end else if (s_fire) begin
      row_q <= row_nx;
      col_q <= col_nx;
      ptr_q <= ptr_nx;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B registers
  // ---------------------------------------------------------------------
  logic                            b_valid_q;
  logic [bws2d_pkg::SampleW-1:0]   b_sample_q;
  logic [SizeW-1:0]                b_col_q;
  logic [RingAW-1:0]               b_ring_addr_q;
  logic                            b_r_zero_q, b_r_ge_w_q, b_c_zero_q, b_c_ge_w_q;
  logic                            b_emit_q, b_last_q;
  logic [bws2d_pkg::CoordW-1:0]    b_win_row_q, b_win_col_q;
  logic                            b_go;
  logic                            out_valid_q;

  // Stage B drains when the output register is free or being taken
  assign b_go          = b_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~b_valid_q | b_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (s_fire) begin
      b_valid_q <= 1'b1;
    end else if (b_go) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      b_sample_q    <= s_axis_tdata;
      b_col_q       <= col_a;
      b_ring_addr_q <= ring_addr_a;
      b_r_zero_q    <= (row_a == '0);
      b_r_ge_w_q    <= (CmpW'(row_a) >= w_eff);
      b_c_zero_q    <= (col_a == '0);
      b_c_ge_w_q    <= (CmpW'(col_a) >= w_eff);
      b_emit_q      <= emit_a;
      b_last_q      <= last_a;
      b_win_row_q   <= bws2d_pkg::CoordW'(row_p1 - w_eff);
      b_win_col_q   <= bws2d_pkg::CoordW'(col_p1 - w_eff);
    end
  end

  // ---------------------------------------------------------------------
  // Row ring and column-sum memories: read at accept, write as B drains.
  // A column is read again no sooner than one row later, so for rows wider
  // than one element the write lands before the next read of the same entry.
  // ---------------------------------------------------------------------
  logic [bws2d_pkg::SampleW-1:0] ring_mem   [RingDepth];
  logic [ColW-1:0]               colsum_mem [MAX_SIZE];
  logic [bws2d_pkg::SampleW-1:0] ring_rd_q;
  logic [ColW-1:0]               colsum_rd_q;
  logic [ColW-1:0]               col_sum;

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      ring_mem[b_ring_addr_q] <= b_sample_q;
      colsum_mem[b_col_q]     <= col_sum;
    end
    if (s_fire) begin
      ring_rd_q   <= ring_mem[ring_addr_a];
      colsum_rd_q <= colsum_mem[col_a];
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: vertical then horizontal running sums
  // ---------------------------------------------------------------------
  logic [ColW-1:0] col_hist_q [MAX_WINDOW];  // column sums of this row, newest first
  logic [BoxW-1:0] row_sum_q;
  logic [ColW-1:0] old_sample;
  logic [HW-1:0]   hist_idx;
  logic [BoxW-1:0] box_sum;

  always_comb begin
    // Drop the sample that leaves the window at the top
    old_sample = b_r_ge_w_q ? ColW'(ring_rd_q) : '0;
    col_sum    = b_r_zero_q ? ColW'(b_sample_q)
                            : colsum_rd_q + ColW'(b_sample_q) - old_sample;
    // Drop the column sum that leaves the window at the left
    hist_idx = HW'(w_eff - CmpW'(1));
    if (b_c_zero_q) begin
      box_sum = BoxW'(col_sum);
    end else if (b_c_ge_w_q) begin
      box_sum = row_sum_q + BoxW'(col_sum) - BoxW'(col_hist_q[hist_idx]);
    end else begin
      box_sum = row_sum_q + BoxW'(col_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q <= '0;
    end else if (b_go) begin
      row_sum_q <= box_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      col_hist_q[0] <= col_sum;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        col_hist_q[i] <= col_hist_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [bws2d_pkg::BoxSumW-1:0] out_sum_q;
  logic [bws2d_pkg::CoordW-1:0]  out_row_q, out_col_q;
  logic                          out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_go) begin
      out_valid_q <= b_emit_q;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      out_sum_q  <= bws2d_pkg::BoxSumW'(box_sum);
      out_row_q  <= b_win_row_q;
      out_col_q  <= b_win_col_q;
      out_last_q <= b_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{bws2d_pkg::OutPadW{1'b0}}, out_col_q, out_row_q, out_sum_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bws2d_pkg::*;

  localparam int MaxSize   = DefaultMaxSize;
  localparam int MaxWindow = DefaultMaxWindow;

  // One expected window result, as the block should emit it
  typedef struct packed {
    logic              is_last;
    logic [CoordW-1:0] left_col;
    logic [CoordW-1:0] top_row;
    logic [BoxSumW-1:0] box_sum;
  } window_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [0:0]           cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SampleW-1:0]   s_axis_tdata;   // [7:0] sample
  logic                 s_axis_tuser;   // [0] frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;   // [13:0] box_sum, [19:14] row, [25:20] col, [31:26] 0
  logic                 m_axis_tlast;   // last_window

  // Local copy of the block state, advanced on every accepted item
  logic [ImageSizeW-1:0]  cfg_image;
  logic [WindowSizeW-1:0] cfg_window;
  logic [SampleW-1:0]     ring_mem [MaxWindow*MaxSize];
  logic [10:0]            col_sum_mem [MaxSize];
  logic [BoxSumW-1:0]     run_sum;
  int unsigned            pos_row;
  int unsigned            pos_col;
  int unsigned            pos_ring;

  window_t     pending_windows[$];
  int unsigned mismatch_count;
  int unsigned pixels_sent;
  bit          steady_tx;
  bit          steady_rx;
  int unsigned rx_hold_cycles;

  box_window_sum_2d i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs a handshake
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Registers are clamped to the legal ranges when used
  function automatic int unsigned side_now();
    if (cfg_image < 1) return 1;
    if (cfg_image > MaxSize) return MaxSize;
    return cfg_image;
  endfunction

  function automatic int unsigned window_now();
    if (cfg_window < 1) return 1;
    if (cfg_window > MaxWindow) return MaxWindow;
    return cfg_window;
  endfunction

  function automatic void restart_position();
    pos_row  = 0;
    pos_col  = 0;
    pos_ring = 0;
    run_sum  = '0;
  endfunction

  // Any register write restarts the scan position
  function automatic void apply_register(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    if (idx == RegImageSize) cfg_image = val[ImageSizeW-1:0];
    else cfg_window = val[WindowSizeW-1:0];
    restart_position();
  endfunction

  // Advance the local state by one pixel and queue the window it completes, if any
  function automatic void predict_window_sum(input logic [SampleW-1:0] px, input logic fs);
    int unsigned n, w, r, c, slot, old_px, vsum;
    window_t     res;
    n = side_now();
    w = window_now();
    if (fs) restart_position();
    if (pos_row >= n || pos_col >= n || pos_ring >= w) restart_position();
    r = pos_row;
    c = pos_col;
    slot = pos_ring * MaxSize + c;

    // vertical sum over the last w rows of this column
    old_px = (r >= w) ? ring_mem[slot] : 0;
    vsum = (r == 0) ? px : col_sum_mem[c] + px - old_px;
    col_sum_mem[c] = vsum[10:0];
    ring_mem[slot] = px;

    // horizontal sum over the last w column sums of this row
    if (c == 0) run_sum = BoxSumW'(vsum);
    else if (c >= w) run_sum = BoxSumW'(run_sum + vsum - col_sum_mem[c-w]);
    else run_sum = BoxSumW'(run_sum + vsum);

    if (w <= n && r + 1 >= w && c + 1 >= w) begin
      res.box_sum  = run_sum;
      res.top_row  = CoordW'(r + 1 - w);
      res.left_col = CoordW'(c + 1 - w);
      res.is_last  = (r + 1 == n && c + 1 == n);
      pending_windows.push_back(res);
    end

    // step to the next raster position; wrap to a new matrix after the last one
    if (c + 1 < n) begin
      pos_col = c + 1;
    end else begin
      pos_col  = 0;
      pos_ring = (pos_ring + 1 >= w) ? 0 : pos_ring + 1;
      if (r + 1 < n) begin
        pos_row = r + 1;
      end else begin
        pos_row  = 0;
        pos_ring = 0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endfunction

  // Compare every accepted result item with the oldest pending window
  always @(posedge clk_i) begin : result_check
    window_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_windows.size() == 0) begin
        note_mismatch("unexpected item, box_sum", 0, m_axis_tdata[BoxSumW-1:0]);
      end else begin
        want = pending_windows.pop_front();
        if (m_axis_tdata[BoxSumW-1:0] !== want.box_sum)
          note_mismatch("box_sum", want.box_sum, m_axis_tdata[BoxSumW-1:0]);
        if (m_axis_tdata[BoxSumW +: CoordW] !== want.top_row)
          note_mismatch("window_row", want.top_row, m_axis_tdata[BoxSumW +: CoordW]);
        if (m_axis_tdata[BoxSumW+CoordW +: CoordW] !== want.left_col)
          note_mismatch("window_col", want.left_col, m_axis_tdata[BoxSumW+CoordW +: CoordW]);
        if (m_axis_tdata[OutDataW-1 -: OutPadW] !== '0)
          note_mismatch("pad bits", 0, m_axis_tdata[OutDataW-1 -: OutPadW]);
        if (m_axis_tlast !== want.is_last)
          note_mismatch("last_window", want.is_last, m_axis_tlast);
      end
    end
  end

  // Result sink: random stall bursts, or a long counted hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        hold_left = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!steady_rx && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Favor the extremes so every window sum edge shows up
  function automatic logic [SampleW-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SampleW'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel, hold it until taken, then advance the predictor
  task automatic send_pixel(input logic [SampleW-1:0] px, input logic fs);
    if (!steady_tx && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_window_sum(px, fs);
    pixels_sent++;
  endtask

  // Send a run of random pixels, optionally marking the first as frame start
  task automatic send_run(input int unsigned count, input bit mark_first);
    for (int unsigned i = 0; i < count; i++) send_pixel(random_pixel(), mark_first && i == 0);
  endtask

  // Drop the input, let every pending window drain, then cover the pipeline latency
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [CfgDataW-1:0] side, input logic [CfgDataW-1:0] win);
    wait_idle();
    write_register(RegImageSize, side);
    write_register(RegWindowSize, win);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset setting (5x5, window 3): saturated top rows, then alternating bit patterns
  task automatic test_defaults();
    for (int i = 0; i < 25; i++)
      send_pixel(i < 15 ? 8'hFF : (i % 2 ? 8'h00 : (i % 4 ? 8'hA5 : 8'h5A)), i == 0);
  endtask

  // Matrices wrap on their own; a frame start in the middle restarts the scan
  task automatic test_wrap_and_restart();
    send_run(50, 1'b0);
    send_run(12, 1'b1);
    send_run(25, 1'b1);
  endtask

  // Zero registers clamp up to 1, oversized window clamps down to MAX_WINDOW
  task automatic test_register_clamp();
    reconfigure(7'd0, 7'd0);
    for (int i = 0; i < 6; i++) send_pixel(random_pixel(), 1'($urandom_range(0, 1)));
    reconfigure(7'd9, 7'd15);
    send_run(81, 1'b1);
  endtask

  // Window larger than the matrix: nothing may come out
  task automatic test_window_exceeds();
    reconfigure(7'd3, 7'd4);
    send_run(18, 1'b1);
    reconfigure(7'd1, 7'd8);
    send_run(5, 1'b0);
  endtask

  // Largest and smallest box sum with the widest window
  task automatic test_sum_extremes();
    reconfigure(7'd8, 7'd8);
    for (int i = 0; i < 64; i++) send_pixel(8'hFF, i == 0);
    for (int i = 0; i < 64; i++) send_pixel(8'h00, i == 0);
  endtask

  // Oversized image register clamps to 64; window 1 covers the first two full rows
  task automatic test_full_frame();
    reconfigure(7'd127, 7'd1);
    send_run(2 * MaxSize, 1'b1);
  endtask

  // Hold the sink off for a long stretch while pixels are offered at full rate
  task automatic test_backpressure();
    reconfigure(7'd6, 7'd2);
    steady_tx = 1'b1;
    rx_hold_cycles = 150;
    send_run(36, 1'b1);
    steady_tx = 1'b0;
  endtask

  // Stop sending mid-matrix until every window is out, then resume the same matrix
  task automatic test_sender_pause();
    reconfigure(7'd7, 7'd3);
    send_run(20, 1'b1);
    s_axis_tvalid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    send_run(29, 1'b0);
    send_run(49, 1'b1);
  endtask

  // Random settings; mostly whole matrices, some cut short or left unmarked
  task automatic test_random_frames();
    int unsigned first, side, win, area, len, left;
    first = pixels_sent;
    while (pixels_sent - first < 340) begin
      case ($urandom_range(0, 19))
        0:          side = $urandom_range(25, 127);
        1, 2, 3, 4: side = $urandom_range(11, 24);
        default:    side = $urandom_range(1, 10);
      endcase
      if ($urandom_range(0, 4) == 0) win = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
      else win = $urandom_range(1, 8);
      wait_idle();
      if ($urandom_range(0, 3) != 0) write_register(RegImageSize, side[CfgDataW-1:0]);
      write_register(RegWindowSize, win[CfgDataW-1:0]);
      repeat ($urandom_range(1, 3)) begin
        area = side_now() * side_now();
        // only a slice of a large matrix
        if (area > 300) area = $urandom_range(60, 300);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, area) : area;
        // keep the total close to the item budget
        left = 340 - (pixels_sent - first);
        if (len > left) len = left;
        send_run(len, $urandom_range(0, 3) != 0);
      end
    end
  endtask

  // Full rate on both sides to close out the run
  task automatic test_steady_finish();
    reconfigure(7'd4, 7'd2);
    steady_tx = 1'b1;
    steady_rx = 1'b1;
    send_run(16, 1'b1);
    send_run(16, 1'b0);
    reconfigure(7'd20, 7'd8);
    send_run(8 * 20 + 8, 1'b1);
  endtask

  task automatic finish_run();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_windows.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  endtask

  initial begin
    // drive every input known from the start and hold reset
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= RegImageSize;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    steady_tx      = 1'b0;
    steady_rx      = 1'b0;
    rx_hold_cycles = 0;
    mismatch_count = 0;
    pixels_sent    = 0;
    cfg_image      = ImageSizeReset;
    cfg_window     = WindowSizeReset;
    ring_mem       = '{default: '0};
    col_sum_mem    = '{default: '0};
    restart_position();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_wrap_and_restart();
    test_register_clamp();
    test_window_exceeds();
    test_sum_extremes();
    test_backpressure();
    test_sender_pause();
    test_full_frame();
    test_random_frames();
    test_steady_finish();
    finish_run();
  end

endmodule
